// ===== design/mrt_pkg.sv =====
// ----------------------------------------------------------------------------
// MPU region table package
// Shared constants, operation and status codes, and the command and status
// structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package mrt_pkg;

  localparam int NUM_REGIONS = 16;
  localparam int ADDR_WIDTH  = 32;
  localparam int FIELD_W     = 32;
  localparam int FLAGS_W     = 32;
  localparam int STATUS_W    = 3;
  localparam int FUNC_W      = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_MAP     = 2'd0,
    FUNC_UNMAP   = 2'd1,
    FUNC_PROTECT = 2'd2,
    FUNC_QUERY   = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_NOT_IDENTITY = 3'd1,
    ST_FULL         = 3'd2,
    ST_OVERLAP      = 3'd3,
    ST_NOT_FOUND    = 3'd4
  } status_e;

  typedef struct packed {
    logic    load;
    logic    scan;
    logic    finish;
    logic    commit;
    status_e status;
  } cmd_t;

  typedef struct packed {
    func_e func;
    logic  id_ok;
    logic  full;
    logic  chk_valid;
    logic  hit;
    logic  last;
    logic  free_any;
    logic  out_busy;
  } sts_t;

endpackage

// ===== design/mrt_if.sv =====
// ----------------------------------------------------------------------------
// MPU region table channel interfaces
// Request and response channels with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface mrt_req_if;
  logic                        valid;
  logic                        ready;
  logic [mrt_pkg::FUNC_W-1:0]  func;
  logic [mrt_pkg::FIELD_W-1:0] addr;
  logic [mrt_pkg::FIELD_W-1:0] phys_addr;
  logic [mrt_pkg::FIELD_W-1:0] region_size;
  logic [mrt_pkg::FLAGS_W-1:0] access_flags;

  modport source (
    output valid, func, addr, phys_addr, region_size, access_flags,
    input  ready
  );
  modport sink (
    input  valid, func, addr, phys_addr, region_size, access_flags,
    output ready
  );
endinterface

interface mrt_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [mrt_pkg::STATUS_W-1:0] status;
  logic [mrt_pkg::FIELD_W-1:0]  found_phys_addr;
  logic [mrt_pkg::FLAGS_W-1:0]  found_flags;

  modport source (
    output valid, status, found_phys_addr, found_flags,
    input  ready
  );
  modport sink (
    input  valid, status, found_phys_addr, found_flags,
    output ready
  );
endinterface

// ===== design/mrt_ctrl.sv =====
// ----------------------------------------------------------------------------
// MPU region table controller
// Sequences one transaction: accept, scan of the table, commit of the result.
// ----------------------------------------------------------------------------
module mrt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mrt_pkg::sts_t sts_i,
  output mrt_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_RESP = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   is_map;

  assign is_map     = (sts_i.func == mrt_pkg::FUNC_MAP);
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.status = mrt_pkg::ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (is_map && !sts_i.id_ok) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = mrt_pkg::ST_NOT_IDENTITY;
          state_d      = S_RESP;
        end else if (is_map && sts_i.full) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = mrt_pkg::ST_FULL;
          state_d      = S_RESP;
        end else if (sts_i.chk_valid && sts_i.hit) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = is_map ? mrt_pkg::ST_OVERLAP : mrt_pkg::ST_OK;
          state_d      = S_RESP;
        end else if (sts_i.last) begin
          cmd_o.finish = 1'b1;
          if (is_map) begin
            cmd_o.status = sts_i.free_any ? mrt_pkg::ST_OK : mrt_pkg::ST_FULL;
          end else begin
            cmd_o.status = mrt_pkg::ST_NOT_FOUND;
          end
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!sts_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/mrt_datapath.sv =====
// ----------------------------------------------------------------------------
// MPU region table datapath
// Region memory, valid bits, use count, scan pipeline and output register.
// ----------------------------------------------------------------------------
module mrt_datapath #(
  parameter int NUM_REGIONS = mrt_pkg::NUM_REGIONS,
  parameter int ADDR_WIDTH  = mrt_pkg::ADDR_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mrt_pkg::cmd_t                cmd_i,
  output mrt_pkg::sts_t                sts_o,
  input  logic [mrt_pkg::FUNC_W-1:0]   func_i,
  input  logic [mrt_pkg::FIELD_W-1:0]  addr_i,
  input  logic [mrt_pkg::FIELD_W-1:0]  phys_addr_i,
  input  logic [mrt_pkg::FIELD_W-1:0]  region_size_i,
  input  logic [mrt_pkg::FLAGS_W-1:0]  access_flags_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [mrt_pkg::STATUS_W-1:0] status_o,
  output logic [mrt_pkg::FIELD_W-1:0]  found_phys_addr_o,
  output logic [mrt_pkg::FLAGS_W-1:0]  found_flags_o
);

  localparam int AW = ADDR_WIDTH;
  localparam int FW = mrt_pkg::FLAGS_W;
  localparam int EW = 2 * AW + FW;
  localparam int IW = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
  localparam int CW = $clog2(NUM_REGIONS + 1);

  logic [EW-1:0] mem [NUM_REGIONS];

  mrt_pkg::func_e           func_q;
  logic [AW-1:0]            addr_q, phys_q, len_q, end_q;
  logic [FW-1:0]            flags_q;
  logic [63:0]              addr_ext, phys_ext, len_ext, addr_out_ext;

  logic [CW-1:0]            rd_cnt_q;
  logic                     chk_v_q;
  logic [IW-1:0]            chk_idx_q;
  logic [EW-1:0]            rd_q;
  logic                     issue;

  logic                     free_found_q;
  logic [IW-1:0]            free_idx_q, free_sel;
  logic [NUM_REGIONS-1:0]   valid_q;
  logic [CW-1:0]            cnt_q;

  mrt_pkg::status_e         res_status_q;
  logic [mrt_pkg::FIELD_W-1:0] res_phys_q;
  logic [FW-1:0]            res_flags_q;
  logic [IW-1:0]            tgt_idx_q;

  logic                     out_valid_q;
  mrt_pkg::status_e         out_status_q;
  logic [mrt_pkg::FIELD_W-1:0] out_phys_q;
  logic [FW-1:0]            out_flags_q;

  logic [AW-1:0]            rb, rl, re;
  logic [FW-1:0]            rf;
  logic                     v, below_end, ovl, exact, inq, hit;
  logic                     commit_ok, mem_we;

  assign addr_ext     = 64'(addr_i);
  assign phys_ext     = 64'(phys_addr_i);
  assign len_ext      = 64'(region_size_i);
  assign addr_out_ext = 64'(addr_q);

  assign rb = rd_q[AW-1:0];
  assign rl = rd_q[2*AW-1:AW];
  assign rf = rd_q[EW-1:2*AW];
  assign re = rb + rl;
  assign v  = valid_q[chk_idx_q];

  assign below_end = (addr_q < re);
  assign ovl       = v && below_end && (end_q > rb);
  assign exact     = v && (rb == addr_q) && (rl == len_q);
  assign inq       = v && below_end && (addr_q >= rb);

  always_comb begin
    unique case (func_q) inside
      mrt_pkg::FUNC_MAP:                        hit = ovl;
      mrt_pkg::FUNC_UNMAP, mrt_pkg::FUNC_PROTECT: hit = exact;
      mrt_pkg::FUNC_QUERY:                      hit = inq;
      default:                                  hit = 1'b0;
    endcase
  end

  assign free_sel = free_found_q ? free_idx_q : chk_idx_q;
  assign issue    = cmd_i.scan && (rd_cnt_q < CW'(NUM_REGIONS));

  assign sts_o.func      = func_q;
  assign sts_o.id_ok     = (phys_q == addr_q);
  assign sts_o.full      = (cnt_q >= CW'(NUM_REGIONS));
  assign sts_o.chk_valid = chk_v_q;
  assign sts_o.hit       = hit;
  assign sts_o.last      = chk_v_q && (chk_idx_q == IW'(NUM_REGIONS - 1));
  assign sts_o.free_any  = free_found_q || (chk_v_q && !v);
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

  assign commit_ok = cmd_i.commit && (res_status_q == mrt_pkg::ST_OK);
  assign mem_we    = commit_ok &&
                     ((func_q == mrt_pkg::FUNC_MAP) || (func_q == mrt_pkg::FUNC_PROTECT));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= mrt_pkg::func_e'(func_i);
      addr_q  <= addr_ext[AW-1:0];
      phys_q  <= phys_ext[AW-1:0];
      len_q   <= len_ext[AW-1:0];
      flags_q <= access_flags_i;
      end_q   <= addr_ext[AW-1:0] + len_ext[AW-1:0];
    end
    if (issue) begin
      rd_q      <= mem[rd_cnt_q[IW-1:0]];
      chk_idx_q <= rd_cnt_q[IW-1:0];
    end
    if (chk_v_q && !v && !free_found_q) begin
      free_idx_q <= chk_idx_q;
    end
    if (cmd_i.finish) begin
      res_status_q <= cmd_i.status;
      tgt_idx_q    <= (func_q == mrt_pkg::FUNC_MAP) ? free_sel : chk_idx_q;
      if ((func_q == mrt_pkg::FUNC_QUERY) && (cmd_i.status == mrt_pkg::ST_OK)) begin
        res_phys_q  <= addr_out_ext[mrt_pkg::FIELD_W-1:0];
        res_flags_q <= rf;
      end else begin
        res_phys_q  <= '0;
        res_flags_q <= '0;
      end
    end
    if (cmd_i.commit) begin
      out_status_q <= res_status_q;
      out_phys_q   <= res_phys_q;
      out_flags_q  <= res_flags_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[tgt_idx_q] <= {flags_q, len_q, addr_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_cnt_q     <= '0;
      chk_v_q      <= 1'b0;
      free_found_q <= 1'b0;
      valid_q      <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        rd_cnt_q     <= '0;
        free_found_q <= 1'b0;
      end else begin
        if (issue) begin
          rd_cnt_q <= rd_cnt_q + CW'(1);
        end
        if (chk_v_q && !v) begin
          free_found_q <= 1'b1;
        end
      end
      chk_v_q <= issue;
      if (commit_ok && (func_q == mrt_pkg::FUNC_MAP)) begin
        valid_q[tgt_idx_q] <= 1'b1;
        cnt_q              <= cnt_q + CW'(1);
      end else if (commit_ok && (func_q == mrt_pkg::FUNC_UNMAP)) begin
        valid_q[tgt_idx_q] <= 1'b0;
        if (cnt_q != '0) begin
          cnt_q <= cnt_q - CW'(1);
        end
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign found_phys_addr_o = out_phys_q;
  assign found_flags_o     = out_flags_q;

endmodule

// ===== design/mpu_region_table_top.sv =====
// ----------------------------------------------------------------------------
// MPU region table
// Protection region table with map, unmap, protect and query operations.
// ----------------------------------------------------------------------------
// The table holds NUM_REGIONS regions in a single-port memory and scans it one
// entry per cycle from acceptance to a registered response. The scan stops
// early at the first matching entry, and a map request that fails its identity
// or table-full check ends before any entry is checked. The one-entry-per-cycle
// scan of the memory read port sets the length of a transaction. A new request
// is taken in the cycle after the previous response enters the output register,
// and that response may wait there while the next request is worked on.
// Region ends wrap modulo 2^ADDR_WIDTH. There is no clearing pass after reset;
// only the valid bits are cleared.
module mpu_region_table_top #(
  parameter int NUM_REGIONS = mrt_pkg::NUM_REGIONS,
  parameter int ADDR_WIDTH  = mrt_pkg::ADDR_WIDTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mrt_req_if.sink    req_i,
  mrt_rsp_if.source  rsp_o
);

  mrt_pkg::cmd_t cmd;
  mrt_pkg::sts_t sts;

  mrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mrt_datapath #(
    .NUM_REGIONS (NUM_REGIONS),
    .ADDR_WIDTH  (ADDR_WIDTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .func_i            (req_i.func),
    .addr_i            (req_i.addr),
    .phys_addr_i       (req_i.phys_addr),
    .region_size_i     (req_i.region_size),
    .access_flags_i    (req_i.access_flags),
    .out_ready_i       (rsp_o.ready),
    .out_valid_o       (rsp_o.valid),
    .status_o          (rsp_o.status),
    .found_phys_addr_o (rsp_o.found_phys_addr),
    .found_flags_o     (rsp_o.found_flags)
  );

endmodule
